/* src/cca_pkg.sv */
// Package for cluster_correlation_average: types, request codes, fixed-point helpers.
package cca_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_POLY,
        ST_MUL,
        ST_RND,
        ST_DIV,
        ST_EMIT
    } cca_state_t;

    localparam logic [1:0] REQ_SPIN   = 2'd0;
    localparam logic [1:0] REQ_COEF   = 2'd1;
    localparam logic [1:0] REQ_MEMBER = 2'd2;

    localparam logic signed [31:0] Q_ONE       = 32'sh0001_0000;
    localparam logic [2:0]         TYPES_RESET = 3'd2;
    localparam int                 DIV_STEPS   = 48;

    // saturate a wide signed value to signed Q15.16
    function automatic logic signed [31:0] sat_q32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -65'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* src/cluster_correlation_average.sv */
// Top level of cluster_correlation_average: stores, member datapath and divider.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata: site_index, spin_value, coef_row, coef_power, coefficient
//                tuser: req_type, last_in_row   tlast: last_in_cluster
// m_axis    out  tdata: correlation, member_count
// cfg       in   cfg_we / cfg_wdata: type_count
//
// A member beat runs through a spin read, one coefficient read and multiply-add per
// term, a row multiply and rounding/accumulate, terms = min(type_count, MAX_TYPES).
// A cluster end adds the 48 steps of the bit-serial divider and the loading of the
// output register.
// Reset clears row product to 1.0, sum, count and position; stores are not cleared.
// A result waiting on m_axis does not block new beats; only a second result stalls.
module cluster_correlation_average
    import cca_pkg::*;
#(
    parameter int SITE_COUNT        = 4096,
    parameter int MAX_CLUSTER_SITES = 8,
    parameter int MAX_TYPES         = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] site_index, [16:12] spin_value, [19:17] coef_row,
    // [21:20] coef_power, [53:22] coefficient, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] req_type, [2] last_in_row
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tlast,   // last_in_cluster
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] correlation, [47:32] member_count
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata       // type_count
);

    localparam int SA_W   = (SITE_COUNT > 2) ? $clog2(SITE_COUNT) : 1;
    localparam int ROWS_W = (MAX_CLUSTER_SITES > 1) ? $clog2(MAX_CLUSTER_SITES) : 1;
    localparam int CDEPTH = MAX_CLUSTER_SITES * MAX_TYPES;
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int TC_W   = $clog2(MAX_TYPES + 1);
    localparam int PW_W   = 4 * (MAX_TYPES - 1) + 2;
    localparam int POLY_W = 32 + PW_W + 3;

    // input fields
    logic [1:0]         req_type;
    logic [11:0]        site_index;
    logic signed [4:0]  spin_value;
    logic [2:0]         coef_row;
    logic [1:0]         coef_power;
    logic signed [31:0] coefficient;
    logic               last_in_row;
    logic               last_in_cluster;

    assign req_type        = s_axis_tuser[1:0];
    assign last_in_row     = s_axis_tuser[2];
    assign last_in_cluster = s_axis_tlast;
    assign site_index      = s_axis_tdata[11:0];
    assign spin_value      = s_axis_tdata[16:12];
    assign coef_row        = s_axis_tdata[19:17];
    assign coef_power      = s_axis_tdata[21:20];
    assign coefficient     = s_axis_tdata[53:22];

    // stores
    logic signed [4:0]  spin_mem [SITE_COUNT];
    logic signed [31:0] coef_mem [CDEPTH];
    logic signed [4:0]  spin_q;
    logic signed [31:0] coef_q;
    logic               spin_we, coef_we, site_ok, coef_ok;
    logic [SA_W-1:0]    spin_addr;
    logic [CA_W-1:0]    coef_waddr, coef_raddr;

    // state
    cca_state_t state_reg, state_next;
    logic [2:0]                type_count_reg;
    logic [ROWS_W-1:0]         pos_reg, pos_next;
    logic signed [31:0]        rowp_reg, rowp_next;
    logic signed [47:0]        sum_reg, sum_next;
    logic [15:0]               cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [31:0]               out_corr_reg, out_corr_next;
    logic [15:0]               out_cnt_reg, out_cnt_next;
    // payload
    logic                      site_ok_reg, site_ok_next;
    logic                      last_row_reg, last_row_next;
    logic                      last_clu_reg, last_clu_next;
    logic signed [4:0]         spin_reg, spin_next;
    logic [TC_W-1:0]           p_reg, p_next;
    logic signed [PW_W-1:0]    pw_reg, pw_next;
    logic signed [POLY_W-1:0]  poly_reg, poly_next;
    logic signed [63:0]        prod_reg, prod_next;
    logic [15:0]               rem_reg, rem_next;
    logic [47:0]               quo_reg, quo_next;
    logic [5:0]                div_i_reg, div_i_next;
    logic                      neg_reg, neg_next;

    // datapath temporaries
    logic                      accept;
    logic [TC_W-1:0]           terms;
    logic signed [31+PW_W:0]   term;
    logic signed [64:0]        prod_rnd;
    logic signed [31:0]        row_val;
    logic signed [48:0]        sum_wide;
    logic signed [47:0]        sum_sat;
    logic [15:0]               cnt_div;
    logic [16:0]               rem_shift;
    logic                      rem_ge;
    logic                      round_up;
    logic [48:0]               quo_rnd;
    logic signed [64:0]        res_wide;
    logic                      out_free;
    logic [ROWS_W-1:0]         pos_inc;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cnt_reg, out_corr_reg};
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign site_ok    = (int'(site_index) < SITE_COUNT);
    assign spin_addr  = SA_W'(site_index);
    assign coef_ok    = (int'(coef_row) < MAX_CLUSTER_SITES) && (int'(coef_power) < MAX_TYPES);
    assign coef_waddr = CA_W'(int'(coef_row) * MAX_TYPES + int'(coef_power));
    assign spin_we    = accept && (req_type == REQ_SPIN) && site_ok;
    assign coef_we    = accept && (req_type == REQ_COEF) && coef_ok;
    assign terms      = (int'(type_count_reg) > MAX_TYPES) ? TC_W'(MAX_TYPES)
                                                           : TC_W'(type_count_reg);
    assign pos_inc    = (int'(pos_reg) == MAX_CLUSTER_SITES - 1) ? '0 : pos_reg + 1'b1;
    assign cnt_div    = (cnt_reg == 16'd0) ? 16'd1 : cnt_reg;

    // coefficient read: next term's entry of the current row
    always_comb
    begin
        if (state_reg == ST_GATHER)
            coef_raddr = CA_W'(int'(pos_reg) * MAX_TYPES);
        else
            coef_raddr = CA_W'(int'(pos_reg) * MAX_TYPES + int'(p_reg) + 1);
    end

    always_ff @(posedge clk)
    begin
        if (spin_we)
            spin_mem[spin_addr] <= spin_value;
        spin_q <= spin_mem[spin_addr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coefficient;
        coef_q <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            type_count_reg <= TYPES_RESET;
        else if (cfg_we)
            type_count_reg <= cfg_wdata;
    end

    // arithmetic of the stages
    assign term      = coef_q * pw_reg;
    assign prod_rnd  = {prod_reg[63], prod_reg} + 65'sd32768;
    assign row_val   = sat_q32(65'(prod_rnd >>> 16));
    assign sum_wide  = {sum_reg[47], sum_reg} + 49'(row_val);
    assign sum_sat   = (sum_wide > 49'sh0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                       (sum_wide < -49'sh0_8000_0000_0000) ? 48'sh8000_0000_0000 :
                       sum_wide[47:0];
    assign rem_shift = {rem_reg, quo_reg[47]};
    assign rem_ge    = (rem_shift >= {1'b0, cnt_div});
    assign round_up  = ({rem_reg, 1'b0} >= {1'b0, cnt_div});
    assign quo_rnd   = {1'b0, quo_reg} + 49'(round_up);
    assign res_wide  = neg_reg ? -65'($signed({1'b0, quo_rnd})) : 65'($signed({1'b0, quo_rnd}));

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rowp_next      = rowp_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_corr_next  = out_corr_reg;
        out_cnt_next   = out_cnt_reg;
        site_ok_next   = site_ok_reg;
        last_row_next  = last_row_reg;
        last_clu_next  = last_clu_reg;
        spin_next      = spin_reg;
        p_next         = p_reg;
        pw_next        = pw_reg;
        poly_next      = poly_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_i_next     = div_i_reg;
        neg_next       = neg_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_MEMBER))
                begin
                    site_ok_next  = site_ok;
                    last_row_next = last_in_row;
                    last_clu_next = last_in_cluster;
                    state_next    = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                spin_next = site_ok_reg ? spin_q : 5'sd0;
                p_next    = '0;
                pw_next   = PW_W'(1);
                poly_next = '0;
                state_next = (terms == '0) ? ST_MUL : ST_POLY;
            end
            ST_POLY:
            begin
                poly_next = poly_reg + POLY_W'(term);
                pw_next   = PW_W'(pw_reg * spin_reg);
                p_next    = p_reg + 1'b1;
                if (p_reg + 1'b1 >= terms)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = rowp_reg * sat_q32(65'(poly_reg));
                state_next = ST_RND;
            end
            ST_RND:
            begin
                rowp_next  = row_val;
                pos_next   = pos_inc;
                state_next = ST_IDLE;
                if (last_row_reg || last_clu_reg)
                begin
                    sum_next  = sum_sat;
                    cnt_next  = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;
                    rowp_next = Q_ONE;
                    pos_next  = '0;
                end
                if (last_clu_reg)
                begin
                    neg_next   = sum_next[47];
                    quo_next   = sum_next[47] ? 48'(-sum_next) : 48'(sum_next);
                    rem_next   = '0;
                    div_i_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next   = rem_ge ? 16'(rem_shift - {1'b0, cnt_div}) : rem_shift[15:0];
                quo_next   = {quo_reg[46:0], rem_ge};
                div_i_next = div_i_reg + 6'd1;
                if (int'(div_i_reg) == DIV_STEPS - 1)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_corr_next  = sat_q32(res_wide);
                    out_cnt_next   = cnt_reg;
                    rowp_next      = Q_ONE;
                    pos_next       = '0;
                    sum_next       = '0;
                    cnt_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            rowp_reg      <= Q_ONE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rowp_reg      <= rowp_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_corr_reg <= out_corr_next;
        out_cnt_reg  <= out_cnt_next;
        site_ok_reg  <= site_ok_next;
        last_row_reg <= last_row_next;
        last_clu_reg <= last_clu_next;
        spin_reg     <= spin_next;
        p_reg        <= p_next;
        pw_reg       <= pw_next;
        poly_reg     <= poly_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_i_reg    <= div_i_next;
        neg_reg      <= neg_next;
    end

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < MAX_CLUSTER_SITES)
        else $error("row position out of range");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != 16'd0))
        else $error("dividing with no rows summed");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> (m_axis_tvalid && cnt_reg == 16'd0
                                                && sum_reg == 48'sd0))
        else $error("emit did not load output and clear sums");

    a_poly_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POLY) |-> (p_reg < terms))
        else $error("term counter past type count");

endmodule
